FILE: hdl/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg
// Shared types, codes and permutation tables of the small matrix inverse.
// ----------------------------------------------------------------------------
package smi_pkg;

  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;
  localparam logic [2:0]  NCOL      = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ORDER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SING_THRESH  = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TERM,
    ST_MUL,
    ST_MWAIT,
    ST_ADD,
    ST_DET,
    ST_DQ1,
    ST_DQ2,
    ST_DQ3,
    ST_COL,
    ST_DIV,
    ST_DWAIT,
    ST_EMIT
  } smi_state_e;

  typedef enum logic [1:0] {
    MAC_NOP,
    MAC_START,
    MAC_MUL,
    MAC_ADD
  } mac_op_e;

  // command from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    mac_op_e                   op;
    logic                      sign;
    logic                      first;
    logic [2:0]                nlimb;
    logic signed [ELEM_W-1:0]  elem;
  } mac_cmd_t;

  // permutations in lexicographic order, digits packed first to last
  localparam logic [7:0] PERM4 [24] = '{
    8'b00_01_10_11, 8'b00_01_11_10, 8'b00_10_01_11, 8'b00_10_11_01,
    8'b00_11_01_10, 8'b00_11_10_01, 8'b01_00_10_11, 8'b01_00_11_10,
    8'b01_10_00_11, 8'b01_10_11_00, 8'b01_11_00_10, 8'b01_11_10_00,
    8'b10_00_01_11, 8'b10_00_11_01, 8'b10_01_00_11, 8'b10_01_11_00,
    8'b10_11_00_01, 8'b10_11_01_00, 8'b11_00_01_10, 8'b11_00_10_01,
    8'b11_01_00_10, 8'b11_01_10_00, 8'b11_10_00_01, 8'b11_10_01_00
  };
  localparam logic [5:0] PERM3 [6] = '{
    6'b00_01_10, 6'b00_10_01, 6'b01_00_10, 6'b01_10_00, 6'b10_00_01, 6'b10_01_00
  };
  localparam logic [3:0] PERM2 [2] = '{4'b00_01, 4'b01_00};

  // odd permutations
  localparam logic [23:0] PAR4 = 24'h666666;
  localparam logic [5:0]  PAR3 = 6'b100110;
  localparam logic [1:0]  PAR2 = 2'b10;

  // column picked for row position i by permutation t of size k
  function automatic logic [1:0] perm_elem(input logic [2:0] k, input logic [4:0] t,
                                           input logic [1:0] i);
    logic [1:0] e;
    e = 2'd0;
    unique case (k)
      3'd4:    e = PERM4[t][(3 - i) * 2 +: 2];
      3'd3:    e = PERM3[t[2:0]][(2 - i) * 2 +: 2];
      3'd2:    e = PERM2[t[0]][(1 - i) * 2 +: 2];
      default: e = 2'd0;
    endcase
    return e;
  endfunction

  function automatic logic perm_par(input logic [2:0] k, input logic [4:0] t);
    logic p;
    p = 1'b0;
    unique case (k)
      3'd4:    p = PAR4[t];
      3'd3:    p = PAR3[t[2:0]];
      3'd2:    p = PAR2[t[0]];
      default: p = 1'b0;
    endcase
    return p;
  endfunction

  function automatic logic [4:0] perm_cnt(input logic [2:0] k);
    logic [4:0] n;
    n = 5'd1;
    unique case (k)
      3'd4:    n = 5'd24;
      3'd3:    n = 5'd6;
      3'd2:    n = 5'd2;
      default: n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/smi_if.sv
// ----------------------------------------------------------------------------
// smi_if
// Request and response channels of the small matrix inverse.
// ----------------------------------------------------------------------------
interface smi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] elem_col0;
  logic signed [31:0] elem_col1;
  logic signed [31:0] elem_col2;
  logic signed [31:0] elem_col3;

  modport source (output valid, elem_col0, elem_col1, elem_col2, elem_col3, input ready);
  modport sink   (input valid, elem_col0, elem_col1, elem_col2, elem_col3, output ready);
endinterface

interface smi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inv_col0;
  logic signed [31:0] inv_col1;
  logic signed [31:0] inv_col2;
  logic signed [31:0] inv_col3;
  logic signed [63:0] determinant;
  logic               singular;
  logic               overflow;
  logic               last_row;

  modport source (output valid, inv_col0, inv_col1, inv_col2, inv_col3, determinant,
                  singular, overflow, last_row, input ready);
  modport sink   (input valid, inv_col0, inv_col1, inv_col2, inv_col3, determinant,
                  singular, overflow, last_row, output ready);
endinterface

FILE: hdl/smi_mac.sv
// ----------------------------------------------------------------------------
// smi_mac
// Shared 32x32 multiplier building one signed product term limb by limb and
// adding it into a wide accumulator.
// ----------------------------------------------------------------------------
module smi_mac #(
  parameter int unsigned PW = 128,
  parameter int unsigned SW = 134
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smi_pkg::mac_cmd_t     cmd_i,
  output logic                  busy_o,
  output logic signed [SW-1:0]  acc_o
);
  import smi_pkg::*;

  logic [PW-1:0]         p_q, pnew_q;
  logic                  psign_q;
  logic [31:0]           emag_q;
  logic [2:0]            limb_q, nl_q, plimb_q;
  logic                  busy_q, prod_v_q;
  logic [63:0]           prod_q;
  logic signed [SW-1:0]  acc_q;
  logic                  issue, fin;
  logic [31:0]           limb_w;
  logic signed [SW-1:0]  pext, term;

  // limb issue and completion
  assign issue  = busy_q && (limb_q < nl_q);
  assign fin    = busy_q && !issue && !prod_v_q;
  assign limb_w = issue ? p_q[32 * limb_q +: 32] : 32'd0;
  assign pext   = SW'(p_q);
  assign term   = psign_q ? -pext : pext;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      prod_v_q <= 1'b0;
      limb_q   <= 3'd0;
      nl_q     <= 3'd0;
    end else begin
      prod_v_q <= issue;
      if (cmd_i.op == MAC_MUL) begin
        busy_q <= 1'b1;
        limb_q <= 3'd0;
        nl_q   <= cmd_i.nlimb;
      end else begin
        if (issue) limb_q <= limb_q + 3'd1;
        if (fin) busy_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (issue) begin
      prod_q  <= limb_w * emag_q;
      plimb_q <= limb_q;
    end
    if (prod_v_q) pnew_q <= pnew_q + (PW'(prod_q) << (32 * plimb_q));
    if (fin) p_q <= pnew_q;
    unique case (cmd_i.op)
      MAC_START: begin
        p_q     <= PW'(1);
        psign_q <= cmd_i.sign;
      end
      MAC_MUL: begin
        emag_q  <= cmd_i.elem[31] ? 32'(-cmd_i.elem) : 32'(cmd_i.elem);
        psign_q <= psign_q ^ cmd_i.elem[31];
        pnew_q  <= '0;
      end
      MAC_ADD: acc_q <= cmd_i.first ? term : acc_q + term;
      default: ;
    endcase
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule

FILE: hdl/smi_div.sv
// ----------------------------------------------------------------------------
// smi_div
// Restoring divider, one quotient bit per cycle: cofactor scaled by twice the
// fraction bits over the determinant, truncated and saturated to 32 bits.
// ----------------------------------------------------------------------------
module smi_div #(
  parameter int unsigned SW        = 134,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [SW-1:0] num_i,
  input  logic signed [SW-1:0] den_i,
  output logic                 done_o,
  output logic [31:0]          quot_o,
  output logic                 ovf_o
);
  import smi_pkg::*;

  localparam int unsigned DVW = SW + 2 * FRAC_BITS + 32;

  logic [DVW-1:0] rem_q, dsh_q;
  logic [31:0]    q_q, quot_q;
  logic [5:0]     cnt_q;
  logic           neg_q, busy_q, chk_q, done_q, ovf_q;
  logic [SW-1:0]  nmag, dmag;
  logic           ge;

  assign nmag = num_i[SW-1] ? SW'(-num_i) : SW'(num_i);
  assign dmag = den_i[SW-1] ? SW'(-den_i) : SW'(den_i);
  assign ge   = rem_q >= dsh_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chk_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        chk_q  <= 1'b1;
      end else if (busy_q && chk_q) begin
        chk_q <= 1'b0;
        cnt_q <= 6'd32;
        if (ge) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (cnt_q != 6'd0) begin
          cnt_q <= cnt_q - 6'd1;
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DVW'(nmag) << (2 * FRAC_BITS);
      dsh_q <= DVW'(dmag) << 32;
      neg_q <= num_i[SW-1] ^ den_i[SW-1];
    end else if (busy_q && chk_q) begin
      dsh_q <= dsh_q >> 1;
      if (ge) begin
        ovf_q  <= 1'b1;
        quot_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end else if (busy_q && cnt_q != 6'd0) begin
      if (ge) rem_q <= rem_q - dsh_q;
      q_q   <= {q_q[30:0], ge};
      dsh_q <= dsh_q >> 1;
    end else if (busy_q) begin
      // sign and saturate the magnitude
      if (!neg_q) begin
        ovf_q  <= q_q[31];
        quot_q <= q_q[31] ? 32'h7FFF_FFFF : q_q;
      end else begin
        ovf_q  <= q_q > 32'h8000_0000;
        quot_q <= (q_q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q_q);
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

endmodule

FILE: hdl/small_matrix_inverse.sv
// ----------------------------------------------------------------------------
// small_matrix_inverse
// Fixed-point inverse of a 2x2, 3x3 or 4x4 matrix by cofactors.
// ----------------------------------------------------------------------------
// The matrix arrives one row per request; rows that do not complete it are
// stored and the block stays ready for the next. The completing row starts
// the computation: the exact determinant as a sum of permutation products,
// then each inverse element as its cofactor over the determinant. All
// products go through one 32x32 multiplier one limb per cycle, and every
// element of a non-singular matrix through a one-bit-per-cycle divider, with
// no request taken until the last inverse row is emitted. One inverse row is
// emitted per response together with the Q32.32 determinant and the singular,
// overflow and last row flags; the next row is computed while a response
// waits to be taken.
module small_matrix_inverse #(
  parameter int unsigned MAX_ORDER = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  smi_in_if.sink                              req_i,
  smi_out_if.source                           rsp_o,
  input  logic                                cfg_we_i,
  input  logic [smi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [smi_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import smi_pkg::*;

  localparam int unsigned PW  = 32 * MAX_ORDER;
  localparam int unsigned SW  = 32 * MAX_ORDER + 6;
  localparam int unsigned DQW = SW + 32;
  localparam int unsigned RIW = $clog2(MAX_ORDER);

  smi_state_e state_q, state_d;

  logic signed [ELEM_W-1:0] store_q [MAX_ORDER][MAX_ORDER];
  logic signed [ELEM_W-1:0] in_cols [4];
  logic [1:0]               rows_q;
  logic [2:0]               order_q, ord;
  logic [31:0]              thr_q;
  logic [4:0]               t_q;
  logic [1:0]               i_q, r_q;
  logic [2:0]               k_q, c_q;
  logic                     cof_q;
  logic signed [SW-1:0]     det_q;
  logic signed [DQW-1:0]    detq, detq_q;
  logic [DQW-1:0]           mag_q;
  logic [63:0]              det64_q;
  logic                     sing_q, ovf_q;
  logic [31:0]              res_q [4];
  logic                     out_valid_q;
  logic signed [31:0]       out_col_q [4];
  logic signed [63:0]       out_det_q;
  logic                     out_sing_q, out_ovf_q, out_last_q;

  logic                     accept, row_last, i_last, t_last, r_last, slot_free, col_use;
  logic [2:0]               rsel, csel;
  logic [1:0]               pe;
  logic signed [ELEM_W-1:0] elem_sel;
  mac_cmd_t                 mac_cmd;
  logic                     mac_busy;
  logic signed [SW-1:0]     acc;
  logic                     div_start, div_done, div_ovf;
  logic [31:0]              div_quot;

  // effective order
  assign ord = (order_q < 3'd2) ? 3'd2 :
               (order_q > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : order_q;

  assign in_cols[0] = req_i.elem_col0;
  assign in_cols[1] = req_i.elem_col1;
  assign in_cols[2] = req_i.elem_col2;
  assign in_cols[3] = req_i.elem_col3;

  assign accept    = req_i.valid && req_i.ready;
  assign row_last  = ({1'b0, rows_q} + 3'd1) >= ord;
  assign i_last    = {1'b0, i_q} == k_q - 3'd1;
  assign t_last    = t_q == perm_cnt(k_q) - 5'd1;
  assign r_last    = {1'b0, r_q} == ord - 3'd1;
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign col_use   = (c_q < ord) && !sing_q;

  // element pick: minors skip row c and column r
  assign pe       = perm_elem(k_q, t_q, i_q);
  assign rsel     = (cof_q && {1'b0, i_q} >= c_q) ? {1'b0, i_q} + 3'd1 : {1'b0, i_q};
  assign csel     = (cof_q && pe >= r_q) ? {1'b0, pe} + 3'd1 : {1'b0, pe};
  assign elem_sel = store_q[rsel[RIW-1:0]][csel[RIW-1:0]];

  // determinant scaled to 32 fraction bits
  always_comb begin
    detq = DQW'(det_q);
    for (int o = 2; o <= MAX_ORDER; o++) begin
      if (ord == 3'(o)) begin
        detq = (DQW'(det_q) <<< ((32 > o * FRAC_BITS) ? 32 - o * FRAC_BITS : 0))
               >>> ((o * FRAC_BITS > 32) ? o * FRAC_BITS - 32 : 0);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && row_last) state_d = ST_TERM;
      ST_TERM:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_MWAIT;
      ST_MWAIT: if (!mac_busy) state_d = i_last ? ST_ADD : ST_MUL;
      ST_ADD:   if (t_last) state_d = cof_q ? ST_DIV : ST_DET;
                else state_d = ST_TERM;
      ST_DET:   state_d = ST_DQ1;
      ST_DQ1:   state_d = ST_DQ2;
      ST_DQ2:   state_d = ST_DQ3;
      ST_DQ3:   state_d = ST_COL;
      ST_COL:   if (c_q == NCOL) state_d = ST_EMIT;
                else if (col_use) state_d = ST_TERM;
      ST_DIV:   state_d = ST_DWAIT;
      ST_DWAIT: if (div_done) state_d = ST_COL;
      ST_EMIT:  if (slot_free) state_d = r_last ? ST_IDLE : ST_COL;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_i.ready   = 1'b0;
    div_start     = 1'b0;
    mac_cmd.op    = MAC_NOP;
    mac_cmd.sign  = 1'b0;
    mac_cmd.first = 1'b0;
    mac_cmd.nlimb = 3'd0;
    mac_cmd.elem  = elem_sel;
    unique case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_TERM: begin
        mac_cmd.op   = MAC_START;
        mac_cmd.sign = perm_par(k_q, t_q) ^ (cof_q & (r_q[0] ^ c_q[0]));
      end
      ST_MUL: begin
        mac_cmd.op    = MAC_MUL;
        mac_cmd.nlimb = (i_q == 2'd0) ? 3'd1 : {1'b0, i_q};
      end
      ST_ADD: begin
        mac_cmd.op    = MAC_ADD;
        mac_cmd.first = t_q == 5'd0;
      end
      ST_DIV:  div_start = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= 2'd0;
      order_q     <= 3'd4;
      thr_q       <= 32'd0;
      out_valid_q <= 1'b0;
      t_q         <= 5'd0;
      i_q         <= 2'd0;
      k_q         <= 3'd0;
      cof_q       <= 1'b0;
      r_q         <= 2'd0;
      c_q         <= 3'd0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MATRIX_ORDER) order_q <= cfg_wdata_i[2:0];
        else if (cfg_idx_i == CFG_SING_THRESH) thr_q <= cfg_wdata_i;
      end
      if (state_q == ST_EMIT && slot_free) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (accept) begin
          if (row_last) begin
            rows_q <= 2'd0;
            cof_q  <= 1'b0;
            k_q    <= ord;
            t_q    <= 5'd0;
          end else begin
            rows_q <= rows_q + 2'd1;
          end
        end
        ST_TERM:  i_q <= 2'd0;
        ST_MWAIT: if (!mac_busy && !i_last) i_q <= i_q + 2'd1;
        ST_ADD:   if (!t_last) t_q <= t_q + 5'd1;
        ST_DQ3: begin
          r_q <= 2'd0;
          c_q <= 3'd0;
        end
        ST_COL: if (c_q != NCOL) begin
          if (col_use) begin
            cof_q <= 1'b1;
            k_q   <= ord - 3'd1;
            t_q   <= 5'd0;
          end else begin
            c_q <= c_q + 3'd1;
          end
        end
        ST_DWAIT: if (div_done) c_q <= c_q + 3'd1;
        ST_EMIT: if (slot_free && !r_last) begin
          r_q <= r_q + 2'd1;
          c_q <= 3'd0;
        end
        default: ;
      endcase
    end
  end

  // matrix store and result datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (accept) begin
        for (int cc = 0; cc < MAX_ORDER; cc++) store_q[rows_q[RIW-1:0]][cc] <= in_cols[cc];
      end
      ST_DET: det_q  <= acc;
      ST_DQ1: detq_q <= detq;
      ST_DQ2: begin
        mag_q <= detq_q[DQW-1] ? DQW'(-detq_q) : DQW'(detq_q);
        if ((&detq_q[DQW-1:63]) || !(|detq_q[DQW-1:63])) det64_q <= detq_q[63:0];
        else det64_q <= detq_q[DQW-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      ST_DQ3: begin
        sing_q <= (mag_q[DQW-1:32] == '0) && (mag_q[31:0] <= thr_q);
        ovf_q  <= 1'b0;
      end
      ST_COL: if (c_q != NCOL && !col_use) res_q[c_q[1:0]] <= 32'd0;
      ST_DWAIT: if (div_done) begin
        res_q[c_q[1:0]] <= div_quot;
        ovf_q           <= ovf_q | div_ovf;
      end
      ST_EMIT: if (slot_free) begin
        for (int cc = 0; cc < 4; cc++) out_col_q[cc] <= res_q[cc];
        out_det_q  <= det64_q;
        out_sing_q <= sing_q;
        out_ovf_q  <= ovf_q;
        out_last_q <= r_last;
        ovf_q      <= 1'b0;
      end
      default: ;
    endcase
  end

  smi_mac #(.PW(PW), .SW(SW)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  smi_div #(.SW(SW), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc),
    .den_i   (det_q),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .ovf_o   (div_ovf)
  );

  // response channel
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.inv_col0    = out_col_q[0];
  assign rsp_o.inv_col1    = out_col_q[1];
  assign rsp_o.inv_col2    = out_col_q[2];
  assign rsp_o.inv_col3    = out_col_q[3];
  assign rsp_o.determinant = out_det_q;
  assign rsp_o.singular    = out_sing_q;
  assign rsp_o.overflow    = out_ovf_q;
  assign rsp_o.last_row    = out_last_q;

endmodule

FILE: hdl/smi_checker.sv
// ----------------------------------------------------------------------------
// smi_checker
// Port-level checks of the small matrix inverse response channel.
// ----------------------------------------------------------------------------
module smi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] col0,
  input logic signed [31:0] col1,
  input logic signed [31:0] col2,
  input logic signed [31:0] col3,
  input logic signed [63:0] det,
  input logic               sing,
  input logic               ovf
);

  // a stalled response holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(col0) && $stable(col1)
      && $stable(col2) && $stable(col3) && $stable(det))
    else $error("response changed while stalled");

  // singular matrix gives an all zero row
  a_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && sing |-> col0 == 0 && col1 == 0 && col2 == 0 && col3 == 0 && !ovf)
    else $error("singular row not zero");

  // overflow only with a saturated element
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && ovf |-> col0 == 32'h7FFF_FFFF || col0 == 32'h8000_0000
      || col1 == 32'h7FFF_FFFF || col1 == 32'h8000_0000
      || col2 == 32'h7FFF_FFFF || col2 == 32'h8000_0000
      || col3 == 32'h7FFF_FFFF || col3 == 32'h8000_0000)
    else $error("overflow without saturation");

endmodule

bind small_matrix_inverse smi_checker u_smi_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (rsp_o.valid),
  .out_ready (rsp_o.ready),
  .col0      (rsp_o.inv_col0),
  .col1      (rsp_o.inv_col1),
  .col2      (rsp_o.inv_col2),
  .col3      (rsp_o.inv_col3),
  .det       (rsp_o.determinant),
  .sing      (rsp_o.singular),
  .ovf       (rsp_o.overflow)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for small_matrix_inverse: feeds matrices row by row,
// predicts determinant, inverse rows and flags in wide integer arithmetic and
// compares every response field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module tb;
  import smi_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [31:0] inv [4];
    logic [63:0] det;
    logic        sing;
    logic        ovf;
    logic        last;
  } inv_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  smi_in_if  req ();
  smi_out_if rsp ();

  small_matrix_inverse dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // predictor state
  logic [31:0] mat_store [4][4];
  int          rows_held;
  logic [2:0]  order_reg;
  logic [31:0] thresh_reg;
  inv_row_t    inv_rows_q [$];

  int errors;
  int cycles;
  int src_idle_pct;
  int snk_idle_pct;
  int hold_left;

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic int eff_order(input logic [2:0] o);
    if (o < 3'd2) return 2;
    if (o > 3'd4) return 4;
    return int'(o);
  endfunction

  // determinant of the top-left k x k block, first-row expansion
  function automatic wide_t block_det(input logic [31:0] m [4][4], input int k);
    wide_t       acc;
    wide_t       term;
    logic [31:0] sub [4][4];
    int          cc;
    acc = '0;
    sub = '{default: '0};
    if (k == 1) begin
      acc = $signed(m[0][0]);
      return acc;
    end
    for (int j = 0; j < k; j++) begin
      for (int r = 1; r < k; r++) begin
        cc = 0;
        for (int c = 0; c < k; c++)
          if (c != j) begin
            sub[r-1][cc] = m[r][c];
            cc++;
          end
      end
      term = block_det(sub, k - 1) * $signed(m[0][j]);
      acc = (j & 1) ? acc - term : acc + term;
    end
    return acc;
  endfunction

  // quotient truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] quot_sat(input wide_t num, input wide_t den,
                                           inout logic ovf);
    logic        neg;
    logic [255:0] n;
    logic [255:0] d;
    logic [255:0] q;
    neg = num[255] != den[255];
    n = num[255] ? -num : num;
    d = den[255] ? -den : den;
    if (d == 0) return 32'h0;
    if (n >= (d << 32)) begin
      ovf = 1'b1;
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    q = n / d;
    if (!neg) begin
      if (q > 256'h7FFF_FFFF) begin
        ovf = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 256'h8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return -q[31:0];
  endfunction

  task automatic predict_inverse(input logic [31:0] row [4]);
    int          ord;
    int          slot;
    wide_t       det;
    wide_t       detq;
    wide_t       mag;
    wide_t       tw;
    wide_t       cof;
    logic        sing;
    logic        fits;
    logic [63:0] det64;
    logic [31:0] sub [4][4];
    int          ri;
    int          ci;
    inv_row_t    e;
    ord = eff_order(order_reg);
    slot = rows_held;
    for (int c = 0; c < 4; c++) mat_store[slot][c] = row[c];
    if (slot + 1 < ord) begin
      rows_held = slot + 1;
      return;
    end
    rows_held = 0;
    det = block_det(mat_store, ord);
    detq = (ord == 2) ? det : det >>> ((ord == 3) ? 16 : 32);
    mag = detq[255] ? -detq : detq;
    tw = '0;
    tw[31:0] = thresh_reg;
    sing = mag <= tw;
    fits = (&detq[255:63]) || !(|detq[255:63]);
    if (fits) det64 = detq[63:0];
    else det64 = detq[255] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    sub = '{default: '0};
    for (int r = 0; r < ord; r++) begin
      e.ovf = 1'b0;
      for (int c = 0; c < 4; c++) begin
        e.inv[c] = 32'h0;
        if (c < ord && !sing) begin
          // minor without row c and column r
          ri = 0;
          for (int i = 0; i < ord; i++)
            if (i != c) begin
              ci = 0;
              for (int j = 0; j < ord; j++)
                if (j != r) begin
                  sub[ri][ci] = mat_store[i][j];
                  ci++;
                end
              ri++;
            end
          cof = block_det(sub, ord - 1);
          if ((r + c) & 1) cof = -cof;
          e.inv[c] = quot_sat(cof <<< 32, det, e.ovf);
        end
      end
      e.det = det64;
      e.sing = sing;
      e.last = (r == ord - 1);
      inv_rows_q.push_back(e);
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      rsp.ready = 1'b0;
      hold_left--;
    end else begin
      rsp.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    inv_row_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (inv_rows_q.size() == 0) begin
        report("unexpected response", rsp.determinant, 64'h0);
      end else begin
        e = inv_rows_q.pop_front();
        if (rsp.inv_col0 !== e.inv[0]) report("inv_col0", rsp.inv_col0, e.inv[0]);
        if (rsp.inv_col1 !== e.inv[1]) report("inv_col1", rsp.inv_col1, e.inv[1]);
        if (rsp.inv_col2 !== e.inv[2]) report("inv_col2", rsp.inv_col2, e.inv[2]);
        if (rsp.inv_col3 !== e.inv[3]) report("inv_col3", rsp.inv_col3, e.inv[3]);
        if (rsp.determinant !== e.det) report("determinant", rsp.determinant, e.det);
        if (rsp.singular !== e.sing) report("singular", rsp.singular, e.sing);
        if (rsp.overflow !== e.ovf) report("overflow", rsp.overflow, e.ovf);
        if (rsp.last_row !== e.last) report("last_row", rsp.last_row, e.last);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_row(input logic [31:0] row [4]);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    req.valid = 1'b1;
    req.elem_col0 = row[0];
    req.elem_col1 = row[1];
    req.elem_col2 = row[2];
    req.elem_col3 = row[3];
    do @(posedge clk_i); while (!req.ready);
    predict_inverse(row);
    @(negedge clk_i);
    req.valid = 1'b0;
  endtask

  task automatic send_matrix(input logic [31:0] m [4][4], input int n);
    for (int r = 0; r < n; r++) send_row(m[r]);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == CFG_MATRIX_ORDER) order_reg = val[2:0];
    else thresh_reg = val;
  endtask

  // wait until every predicted row is back, plus a margin for a busy block
  task automatic drain();
    while (inv_rows_q.size() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rnd_elem(input int kind, input bit diag);
    case (kind)
      0:       return $urandom;
      1:       return (diag ? 32'h0001_0000 : 32'h0) + (int'($urandom_range(8191)) - 4096);
      2:       return int'($urandom_range(524288)) - 262144;
      default: return int'($urandom_range(511)) - 256;
    endcase
  endfunction

  function automatic void diag_matrix(output logic [31:0] m [4][4], input logic [31:0] d0,
                                      input logic [31:0] d1, input logic [31:0] d2,
                                      input logic [31:0] d3);
    m = '{default: '0};
    m[0][0] = d0;
    m[1][1] = d1;
    m[2][2] = d2;
    m[3][3] = d3;
  endfunction

  task automatic test_identity();
    logic [31:0] m [4][4];
    diag_matrix(m, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000);
    send_matrix(m, 4);
    drain();
  endtask

  // order register above range acts as four; extreme element values
  task automatic test_extremes();
    logic [31:0] m [4][4];
    write_cfg(CFG_MATRIX_ORDER, 32'd7);
    m = '{default: 32'h8000_0000};
    for (int i = 0; i < 4; i++) m[i][i] = 32'h7FFF_FFFF;
    m[1][2] = 32'hFFFF_FFFF;
    m[3][0] = 32'h0000_0001;
    send_matrix(m, 4);
    drain();
  endtask

  // order below range acts as two: tiny, zero and negative matrices
  task automatic test_order_two();
    logic [31:0] m [4][4];
    write_cfg(CFG_MATRIX_ORDER, 32'd1);
    diag_matrix(m, 32'h1, 32'h1, 32'h0, 32'h0);
    send_matrix(m, 2);
    m = '{default: '0};
    send_matrix(m, 2);
    drain();
    write_cfg(CFG_MATRIX_ORDER, 32'd2);
    m = '{'{32'hFFFE_0000, 32'h0000_8000, 32'h1234_5678, 32'hDEAD_BEEF},
          '{32'h0003_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF},
          '{default: '0}, '{default: '0}};
    send_matrix(m, 2);
    drain();
  endtask

  // half determinant falls under the largest threshold
  task automatic test_threshold();
    logic [31:0] m [4][4];
    write_cfg(CFG_MATRIX_ORDER, 32'd3);
    write_cfg(CFG_SING_THRESH, 32'hFFFF_FFFF);
    diag_matrix(m, 32'h8000, 32'h1_0000, 32'h1_0000, 32'h0);
    send_matrix(m, 3);
    drain();
    write_cfg(CFG_SING_THRESH, 32'h0);
  endtask

  // order lowered while rows are pending: next row completes the matrix
  task automatic test_short_collection();
    logic [31:0] m [4][4];
    write_cfg(CFG_MATRIX_ORDER, 32'd4);
    diag_matrix(m, 32'h2_0000, 32'hFFFF_0000, 32'h3_0000, 32'h1_0000);
    m[0][1] = 32'h0000_4000;
    send_matrix(m, 2);
    repeat (20) @(negedge clk_i);
    write_cfg(CFG_MATRIX_ORDER, 32'd2);
    send_row(m[2]);
    drain();
  endtask

  task automatic random_config();
    drain();
    if ($urandom_range(9) == 0) write_cfg(CFG_MATRIX_ORDER, $urandom_range(7));
    else write_cfg(CFG_MATRIX_ORDER, $urandom_range(4, 2));
    case ($urandom_range(3))
      0:       write_cfg(CFG_SING_THRESH, $urandom);
      1:       write_cfg(CFG_SING_THRESH, $urandom_range(65535));
      default: write_cfg(CFG_SING_THRESH, 32'h0);
    endcase
  endtask

  task automatic test_random(input int src_pct, input int snk_pct, input int n_items);
    logic [31:0] m [4][4];
    int sent;
    int kind;
    int ord;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(5) == 0) random_config();
      ord = eff_order(order_reg);
      kind = $urandom_range(5);
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          m[r][c] = rnd_elem(kind == 5 ? 0 : (kind == 4 ? 1 : kind), r == c);
      // rank deficient: repeated row
      if (kind == 4 && $urandom_range(1)) m[ord-1] = m[0];
      send_matrix(m, ord);
      sent += ord;
    end
    drain();
  endtask

  // receiver holds off while rows keep coming, then sender waits for all
  task automatic test_backpressure();
    logic [31:0] m [4][4];
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_cfg(CFG_MATRIX_ORDER, 32'd2);
    hold_left = 3000;
    for (int k = 0; k < 8; k++) begin
      for (int r = 0; r < 2; r++)
        for (int c = 0; c < 4; c++) m[r][c] = rnd_elem(1, r == c);
      send_matrix(m, 2);
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.elem_col0 = '0;
    req.elem_col1 = '0;
    req.elem_col2 = '0;
    req.elem_col3 = '0;
    rsp.ready = 1'b0;
    errors = 0;
    cycles = 0;
    hold_left = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    mat_store = '{default: '0};
    rows_held = 0;
    order_reg = 3'd4;
    thresh_reg = 32'h0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_identity();
    test_extremes();
    test_order_two();
    test_threshold();
    test_short_collection();
    test_random(32, 55, 42);
    test_random(55, 32, 42);
    test_random(0, 0, 42);
    test_backpressure();

    drain();
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/smi_pkg.sv
hdl/smi_if.sv
hdl/smi_mac.sv
hdl/smi_div.sv
hdl/small_matrix_inverse.sv
hdl/smi_checker.sv
tb/sv/tb.sv
